FILE: rtl/core/msp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package msp_pkg;

	localparam int MOTORS_DEF = 3;

	localparam int SPEED_W  = 16;
	localparam int SF_W     = 8;
	localparam int POL_W    = 3;
	localparam int PERIOD_W = 16;
	localparam int IDX_W    = 2;
	localparam int DIR_W    = 2;
	localparam int LVL_W    = 3;

	// speed numerator and the widths of the period division
	localparam int          NUM_W     = 17;
	localparam logic [16:0] SPEED_NUM = 17'd100000;
	localparam int          DEN_W     = 25;
	localparam int          DCNT_W    = $clog2(NUM_W + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SF0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SF1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SF2       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CW_POL    = 3'd5;

	localparam logic [DIR_W-1:0] DIR_CCW = 2'd0;
	localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;

	typedef enum logic [2:0] {
		OP_TICK_ALL    = 3'd0,
		OP_TICK_ONE    = 3'd1,
		OP_SET_SPEED   = 3'd2,
		OP_SET_DIR     = 3'd3,
		OP_ENABLE      = 3'd4,
		OP_DISABLE     = 3'd5,
		OP_ENABLE_ALL  = 3'd6,
		OP_DISABLE_ALL = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic apply;
		logic mul;
		logic wr_period;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/msp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module msp_div import msp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DEN_W-1:0]    den,
	output logic                     done,
	output logic [PERIOD_W-1:0]      quo
);

	logic              busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(NUM_W);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= SPEED_NUM;
			den_q <= den;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	// a zero divisor leaves all ones in the quotient
	assign done = busy_q && (cnt_q == '0);
	assign quo  = quo_q[PERIOD_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/core/msp_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module msp_dpath import msp_pkg::*; #(
	parameter int MOTORS = MOTORS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire op_t                   in_op,
	input  wire logic [IDX_W-1:0]      in_idx,
	input  wire logic [SPEED_W-1:0]    in_speed,
	input  wire logic [DIR_W-1:0]      in_dir,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire dp_cmd_t               cmd,
	output dp_stat_t                   stat,
	output logic [LVL_W-1:0]           step_levels,
	output logic [LVL_W-1:0]           dir_levels
);

	localparam int CMP_W = 4;

	logic [SPEED_W-1:0]  max_speed_q;
	logic [SPEED_W-1:0]  min_speed_q;
	logic [SF_W-1:0]     sf0_q;
	logic [SF_W-1:0]     sf1_q;
	logic [SF_W-1:0]     sf2_q;
	logic [POL_W-1:0]    pol_q;

	logic [PERIOD_W-1:0] period_q [MOTORS];
	logic [PERIOD_W-1:0] count_q  [MOTORS];
	logic [MOTORS-1:0]   en_q;
	logic [MOTORS-1:0]   step_q;
	logic [MOTORS-1:0]   dir_q;

	logic [IDX_W-1:0]    idx_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [LVL_W-1:0]    step_out_q;
	logic [LVL_W-1:0]    dir_out_q;

	logic [MOTORS-1:0]   hit_in;
	logic [MOTORS-1:0]   hit_q;
	logic [MOTORS-1:0]   tick_en;
	logic                cw_sel;
	logic [SF_W-1:0]     sf_sel;
	logic [SPEED_W-1:0]  speed_clamp;
	logic [DEN_W-1:0]    den;
	logic [PERIOD_W-1:0] div_quo;
	logic                div_done;
	logic [LVL_W-1:0]    step_now;
	logic [LVL_W-1:0]    dir_now;

	always_comb begin
		for (int i = 0; i < MOTORS; i++) begin
			hit_in[i]  = (CMP_W'(in_idx) == CMP_W'(i));
			hit_q[i]   = (CMP_W'(idx_q) == CMP_W'(i));
			tick_en[i] = cmd.apply && en_q[i] && (period_q[i] != '0) &&
				((in_op == OP_TICK_ALL) || ((in_op == OP_TICK_ONE) && hit_in[i]));
		end
	end

	// motors past the third use polarity 0 and step factor 1
	always_comb begin
		case (in_idx)
			2'd0:    cw_sel = pol_q[0];
			2'd1:    cw_sel = pol_q[1];
			2'd2:    cw_sel = pol_q[2];
			default: cw_sel = 1'b0;
		endcase
	end

	always_comb begin
		case (idx_q)
			2'd0:    sf_sel = sf0_q;
			2'd1:    sf_sel = sf1_q;
			2'd2:    sf_sel = sf2_q;
			default: sf_sel = SF_W'(1);
		endcase
	end

	always_comb begin
		if (speed_q > max_speed_q) begin
			speed_clamp = max_speed_q;
		end else if (speed_q < min_speed_q) begin
			speed_clamp = min_speed_q;
		end else begin
			speed_clamp = speed_q;
		end
	end

	assign den = DEN_W'({sf_sel, 1'b0}) * DEN_W'(speed_clamp);

	msp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign stat.need_div = (in_op == OP_SET_SPEED) && (|hit_in);
	assign stat.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= SPEED_W'(1000);
			min_speed_q <= SPEED_W'(1);
			sf0_q       <= SF_W'(40);
			sf1_q       <= SF_W'(60);
			sf2_q       <= SF_W'(4);
			pol_q       <= '1;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_MAX_SPEED: max_speed_q <= cfg_wdata;
				REG_MIN_SPEED: min_speed_q <= cfg_wdata;
				REG_SF0:       sf0_q       <= cfg_wdata[SF_W-1:0];
				REG_SF1:       sf1_q       <= cfg_wdata[SF_W-1:0];
				REG_SF2:       sf2_q       <= cfg_wdata[SF_W-1:0];
				REG_CW_POL:    pol_q       <= cfg_wdata[POL_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTORS; i++) begin
				period_q[i] <= '0;
				count_q[i]  <= '0;
			end
			en_q   <= '0;
			step_q <= '0;
			dir_q  <= '0;
		end else begin
			for (int i = 0; i < MOTORS; i++) begin
				if (tick_en[i]) begin
					// counter wraps at 16 bits if the period dropped below it
					if (count_q[i] + 1'b1 == period_q[i]) begin
						step_q[i]  <= ~step_q[i];
						count_q[i] <= '0;
					end else begin
						count_q[i] <= count_q[i] + 1'b1;
					end
				end
				if (cmd.wr_period && hit_q[i]) begin
					period_q[i] <= div_quo;
				end
				if (cmd.apply) begin
					case (in_op)
						OP_SET_DIR: begin
							if (hit_in[i] && in_dir == DIR_CW) begin
								dir_q[i] <= cw_sel;
							end else if (hit_in[i] && in_dir == DIR_CCW) begin
								dir_q[i] <= ~cw_sel;
							end
						end
						OP_ENABLE: begin
							if (hit_in[i]) begin
								en_q[i] <= 1'b1;
							end
						end
						OP_DISABLE: begin
							if (hit_in[i]) begin
								en_q[i] <= 1'b0;
							end
						end
						OP_ENABLE_ALL:  en_q[i] <= 1'b1;
						OP_DISABLE_ALL: en_q[i] <= 1'b0;
						default:        ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			idx_q   <= in_idx;
			speed_q <= in_speed;
		end
		if (cmd.load_out) begin
			step_out_q <= step_now;
			dir_out_q  <= dir_now;
		end
	end

	for (genvar g = 0; g < LVL_W; g++) begin : g_lvl
		if (g < MOTORS) begin : g_on
			assign step_now[g] = step_q[g];
			assign dir_now[g]  = dir_q[g];
		end else begin : g_off
			assign step_now[g] = 1'b0;
			assign dir_now[g]  = 1'b0;
		end
	end

	assign step_levels = step_out_q;
	assign dir_levels  = dir_out_q;

endmodule
`default_nettype wire

FILE: rtl/core/msp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module msp_ctrl import msp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = stat.need_div ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL:  state_next = ST_DIV;
			ST_DIV: begin
				if (stat.div_done) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.apply = in_valid;
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_DIV:  cmd.wr_period = stat.div_done;
			ST_DONE: cmd.load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/core/multi_stepper_pulse_generator.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser op, s_tdata motor/speed/dir
// m_*       out  m_tvalid/m_tready  m_tdata step and dir line levels
// cfg_*     in   cfg_wen            cfg_index, cfg_wdata, no read-back
//
// tick, dir and enable commands go from accept straight to the done state, which
// loads the output register once it is free; set speed to a motor first runs a multiply
// state, then the bit-serial period divider works out 17 quotient bits
// a result held in the output register lets one more item in; that item waits
// for the register and keeps s_tready low until m_tready frees it
// arst_n clears the motor state and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none
module multi_stepper_pulse_generator import msp_pkg::*; #(
	parameter int MOTORS = MOTORS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [23:0]           s_tdata,   // motor_index, speed_value, dir_value
	input  wire logic [2:0]            s_tuser,   // op
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // step_levels, dir_levels
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [LVL_W-1:0] step_levels;
	logic [LVL_W-1:0] dir_levels;

	msp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	msp_dpath #(
		.MOTORS (MOTORS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_op       (op_t'(s_tuser)),
		.in_idx      (s_tdata[1:0]),
		.in_speed    (s_tdata[17:2]),
		.in_dir      (s_tdata[19:18]),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.stat        (stat),
		.step_levels (step_levels),
		.dir_levels  (dir_levels)
	);

	assign m_tdata = {2'b00, dir_levels, step_levels};

endmodule
`default_nettype wire
